@@ hdl/wbps_pkg.sv @@
// Shared types, sizes and register codes of the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

	// Window and pattern sizes
	localparam int MAX_PATTERN = 16;
	localparam int PAT_BYTES   = 16;
	localparam int OFFSET_BITS = 32;
	localparam int ADDR_W      = 64;
	localparam int LEN_W       = 5;
	localparam int CARE_W      = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int HELD_W      = $clog2(MAX_PATTERN + 1);
	localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd4;

	// Byte window, entry 0 newest
	typedef logic [MAX_PATTERN-1:0][7:0] win_t;

	// Pattern bytes, byte 0 lowest
	typedef logic [PAT_BYTES-1:0][7:0] pat_t;

	// Configuration seen by the compare logic
	typedef struct packed {
		pat_t              pattern;
		logic [CARE_W-1:0] care;
		logic [LEN_W-1:0]  length;
		logic [ADDR_W-1:0] start;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/wildcard_byte_pattern_scan.sv @@
// Top level of the wildcard byte pattern scanner: stream ports, state and result register.
`default_nettype none

// The scanner takes one region byte per transaction and reports at most one result per
// region: found with the match address at the first match, or not found on the last byte
// when nothing matched. A byte is held in an input register, is compared with the pattern
// against a 16-byte window and then lands in the result register, so one byte is taken
// every cycle while the result side keeps up. The rate is set by the combinational window
// compare and the 64-bit address add. Bytes after a match are consumed without result until
// the region's last byte clears the state. Configuration may change inside a region, but the
// user must write it only with no transaction in flight; the block does not enforce this.

module wildcard_byte_pattern_scan
	import wbps_pkg::*;
(
	input  var logic                  clk,
	input  var logic                  arst_n,
	// Configuration write port
	input  var logic                  cfg_we,
	input  var logic [CFG_IDX_W-1:0]  cfg_index,
	input  var logic [CFG_DATA_W-1:0] cfg_wdata,
	// Region bytes
	input  var logic                  s_axis_tvalid,
	output logic                      s_axis_tready,
	input  var logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  var logic                  s_axis_tlast,   // last_byte
	// Results
	output logic                      m_axis_tvalid,
	input  var logic                  m_axis_tready,
	output logic [ADDR_W-1:0]         m_axis_tdata,   // [63:0] match_address
	output logic                      m_axis_tuser    // [0] found
);

	cfg_t                   cfg_q;
	logic                   s1_valid_s1;
	logic [7:0]             s1_byte_s1;
	logic                   s1_last_s1;
	win_t                   win_q;
	logic [HELD_W-1:0]      held_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   found_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [ADDR_W-1:0]      out_addr_q;

	win_t                   win_next;
	logic [HELD_W-1:0]      held_next;
	logic                   match;
	logic                   proc;
	logic                   emit;
	logic [OFFSET_BITS-1:0] start_off;
	logic [ADDR_W-1:0]      match_addr;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  cfg_q.pattern[7:0]  <= cfg_wdata;
				REG_PAT_HIGH: cfg_q.pattern[15:8] <= cfg_wdata;
				REG_CARE:     cfg_q.care          <= cfg_wdata[CARE_W-1:0];
				REG_LENGTH:   cfg_q.length        <= cfg_wdata[LEN_W-1:0];
				REG_START:    cfg_q.start         <= cfg_wdata[ADDR_W-1:0];
				default:      ;
			endcase
		end
	end

	// Advance the held byte when the result register is free or being drained
	assign proc          = s1_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || proc;

	// Shift the new byte into the window and saturate the fill count
	assign win_next  = {win_q[MAX_PATTERN-2:0], s1_byte_s1};
	assign held_next = (int'(held_q) == MAX_PATTERN) ? held_q : held_q + 1'b1;

	wbps_match u_match (
		.window (win_next),
		.held   (held_next),
		.cfg    (cfg_q),
		.match  (match)
	);

	// Match start offset and address
	assign start_off  = offset_q + OFFSET_BITS'(1) - OFFSET_BITS'(cfg_q.length);
	assign match_addr = cfg_q.start + ADDR_W'(start_off);
	assign emit       = !found_q && (match || s1_last_s1);

	// Hold one byte in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_byte_s1 <= s_axis_tdata;
			s1_last_s1 <= s_axis_tlast;
		end
	end

	// Update scan state; the last byte clears it for the next region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			held_q   <= '0;
			offset_q <= '0;
			found_q  <= 1'b0;
		end else if (proc) begin
			if (s1_last_s1) begin
				win_q    <= '0;
				held_q   <= '0;
				offset_q <= '0;
				found_q  <= 1'b0;
			end else begin
				offset_q <= offset_q + 1'b1;
				if (!found_q) begin
					win_q   <= win_next;
					held_q  <= held_next;
					found_q <= match;
				end
			end
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_found_q <= match;
			out_addr_q  <= match ? match_addr : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_addr_q;
	assign m_axis_tuser  = out_found_q;

	// A region's last byte leaves the scan state empty
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && s1_last_s1 |=> held_q == '0 && offset_q == '0 && !found_q)
		else $error("scan state not cleared after last byte");

	// A not-found result carries a zero address
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_addr_q == '0)
		else $error("not-found result with nonzero address");

	// The fill count never passes the window depth
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_q) <= MAX_PATTERN)
		else $error("window fill count out of range");

	// No result while the region is already matched, except none at all
	a_no_second: assert property (@(posedge clk) disable iff (!arst_n)
		proc && found_q |=> !out_valid_q || $stable(out_addr_q))
		else $error("second result after a match");

	// Stalling the input only happens with a byte held
	a_ready_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a held byte");

endmodule

`default_nettype wire

@@ hdl/wbps_match.sv @@
// Parallel wildcard compare of the newest window bytes against the pattern.
`default_nettype none

module wbps_match
	import wbps_pkg::*;
(
	input  var win_t              window,
	input  var logic [HELD_W-1:0] held,
	input  var cfg_t              cfg,
	output logic                  match
);

	// Compare pattern byte j with the byte that arrived length-1-j bytes ago
	always_comb begin
		logic                 ok;
		logic [WIN_IDX_W-1:0] idx;
		ok  = 1'b1;
		idx = '0;
		if (cfg.length == '0 || int'(cfg.length) > PAT_BYTES ||
				int'(cfg.length) > MAX_PATTERN) begin
			ok = 1'b0;
		end else if (int'(held) < int'(cfg.length)) begin
			ok = 1'b0;
		end else begin
			for (int j = 0; j < PAT_BYTES; j++) begin
				idx = WIN_IDX_W'(int'(cfg.length) - 1 - j);
				if (j < int'(cfg.length) && cfg.care[j] &&
						window[idx] != cfg.pattern[j]) begin
					ok = 1'b0;
				end
			end
		end
		match = ok;
	end

endmodule

`default_nettype wire

@@ tb/scan_result_checker.sv @@
// Result checker of the wildcard byte pattern scanner: predicts each region result and compares.
module scan_result_checker
	import wbps_pkg::*;
(
	input  var logic                  clk,
	input  var logic                  arst_n,
	input  var logic                  cfg_we,
	input  var logic [CFG_IDX_W-1:0]  cfg_index,
	input  var logic [CFG_DATA_W-1:0] cfg_wdata,
	input  var logic                  s_axis_tvalid,
	input  var logic                  s_axis_tready,
	input  var logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  var logic                  s_axis_tlast,   // last_byte
	input  var logic                  m_axis_tvalid,
	input  var logic                  m_axis_tready,
	input  var logic [ADDR_W-1:0]     m_axis_tdata,   // [63:0] match_address
	input  var logic                  m_axis_tuser,   // [0] found
	output int                        mismatches,
	output int                        results_owed,
	output int                        found_count,
	output int                        miss_count
);

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] address;
	} scan_result_t;

	scan_result_t expected_results[$];
	scan_result_t want;

	// Register copies as the compare sees them
	logic [2*ADDR_W-1:0] pat_words;   // {pattern_bytes_high, pattern_bytes_low}
	logic [CARE_W-1:0]   care;
	logic [LEN_W-1:0]    pat_len;
	logic [ADDR_W-1:0]   base_addr;

	// Scan state of the current region
	win_t                   recent;      // entry 0 newest
	int                     held;
	logic [OFFSET_BITS-1:0] offset;
	logic                   matched;

	// Check the newest pat_len bytes against the pattern, wildcards skipped
	function automatic logic window_hit();
		int n;
		n = pat_len;
		if (n == 0 || n > PAT_BYTES || n > MAX_PATTERN || held < n)
			return 1'b0;
		for (int j = 0; j < n; j++)
			if (care[j] && recent[n-1-j] != pat_words[8*j +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the region state by one byte and queue any result it causes
	task automatic scan_byte(input logic [7:0] b, input logic last);
		logic [OFFSET_BITS-1:0] start_off;
		scan_result_t r;
		if (!matched) begin
			for (int i = MAX_PATTERN - 1; i > 0; i--)
				recent[i] = recent[i-1];
			recent[0] = b;
			if (held < MAX_PATTERN)
				held++;
			if (window_hit()) begin
				start_off = offset + 1 - OFFSET_BITS'(pat_len);
				r.found = 1'b1;
				r.address = base_addr + ADDR_W'(start_off);
				expected_results.insert(expected_results.size(), r);
				matched = 1'b1;
			end
		end
		offset = offset + 1'b1;
		if (last) begin
			if (!matched) begin
				r.found = 1'b0;
				r.address = '0;
				expected_results.insert(expected_results.size(), r);
			end
			recent = '0;
			held = 0;
			offset = '0;
			matched = 1'b0;
		end
	endtask

	task automatic count_mismatch(input string msg);
		if (mismatches < 10)
			$display("%s", msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			pat_words = '0;
			care = '0;
			pat_len = '0;
			base_addr = '0;
			recent = '0;
			held = 0;
			offset = '0;
			matched = 1'b0;
			mismatches = 0;
			results_owed = 0;
			found_count = 0;
			miss_count = 0;
		end else begin
			// Compare a result transaction with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (m_axis_tuser)
					found_count++;
				else
					miss_count++;
				if (expected_results.size() == 0) begin
					count_mismatch($sformatf("unexpected result: found=%0b addr=%h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser !== want.found || m_axis_tdata !== want.address)
						count_mismatch($sformatf(
							"mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
							want.found, want.address, m_axis_tuser, m_axis_tdata));
				end
			end

			// Track register writes; indexes past the last register are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_PAT_LOW:  pat_words[ADDR_W-1:0] = cfg_wdata;
					REG_PAT_HIGH: pat_words[2*ADDR_W-1:ADDR_W] = cfg_wdata;
					REG_CARE:     care = cfg_wdata[CARE_W-1:0];
					REG_LENGTH:   pat_len = cfg_wdata[LEN_W-1:0];
					REG_START:    base_addr = cfg_wdata;
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready)
				scan_byte(s_axis_tdata, s_axis_tlast);
			results_owed = expected_results.size();
		end
	end

endmodule

@@ tb/tb_wildcard_byte_pattern_scan.sv @@
// Testbench top of the wildcard byte pattern scanner: clock, reset, stimulus and verdict.
module tb_wildcard_byte_pattern_scan;
	import wbps_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_BYTES  = 1400;
	localparam int CALM_FROM     = 1150;
	localparam int SETTLE_CYCLES = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;     // [7:0] data_byte
	logic                  s_axis_tlast = 1'b0;   // last_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [ADDR_W-1:0]     m_axis_tdata;          // [63:0] match_address
	logic                  m_axis_tuser;          // [0] found

	int mismatches;
	int results_owed;
	int found_count;
	int miss_count;

	bit calm = 1'b0;
	int cycles = 0;
	int stall_left = 0;
	int bytes_sent = 0;
	int regions_sent = 0;
	int settings_used = 0;

	// Pattern as last written, used to plant matches and near misses
	logic [2*ADDR_W-1:0] gen_pat = '0;
	logic [CARE_W-1:0]   gen_care = '0;
	int                  gen_len = 0;

	wildcard_byte_pattern_scan u_top (.*);
	scan_result_checker u_check (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side in short random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PAT_LOW:  gen_pat[ADDR_W-1:0] = val;
			REG_PAT_HIGH: gen_pat[2*ADDR_W-1:ADDR_W] = val;
			REG_CARE:     gen_care = val[CARE_W-1:0];
			REG_LENGTH:   gen_len = val[LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	// Offer one byte, hold it until the transaction completes
	task automatic put_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 3) == 0)
			idle_sender($urandom_range(1, 5));
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Hold off until every expected result is in and the pipeline is empty
	task automatic settle(input int extra);
		idle_sender(1);
		while (results_owed != 0)
			@(negedge clk);
		repeat (extra)
			@(negedge clk);
	endtask

	// Random byte, often a pattern byte to make near misses
	function automatic logic [7:0] filler();
		int k;
		k = $urandom_range(0, PAT_BYTES - 1);
		if ($urandom_range(0, 2) == 0)
			return gen_pat[8*k +: 8];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Send one region, optionally with the pattern planted after a random prefix
	task automatic send_region(input bit plant);
		logic [7:0] bytes[$];
		int pre;
		if (plant && gen_len >= 1 && gen_len <= PAT_BYTES) begin
			pre = $urandom_range(0, 10);
			repeat (pre)
				bytes.insert(bytes.size(), filler());
			for (int j = 0; j < gen_len; j++)
				bytes.insert(bytes.size(),
					gen_care[j] ? gen_pat[8*j +: 8] : 8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 5))
				bytes.insert(bytes.size(), filler());
		end else begin
			repeat ($urandom_range(1, 24))
				bytes.insert(bytes.size(), filler());
		end
		for (int i = 0; i < bytes.size(); i++)
			put_byte(bytes[i], i == bytes.size() - 1);
		bytes_sent += bytes.size();
		regions_sent++;
	endtask

	// Pick a new register setting, extremes included, and write it while idle
	task automatic apply_setting();
		logic [CFG_DATA_W-1:0] v;
		settle(SETTLE_CYCLES);
		write_reg(REG_PAT_LOW, pick_word());
		write_reg(REG_PAT_HIGH, pick_word());

		v = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: v[CARE_W-1:0] = '0;
			1: v[CARE_W-1:0] = '1;
			default: v[CARE_W-1:0] = CARE_W'($urandom);
		endcase
		write_reg(REG_CARE, v);

		v = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v[LEN_W-1:0] = '0;
			1: v[LEN_W-1:0] = LEN_W'(1);
			2, 3: v[LEN_W-1:0] = LEN_W'(PAT_BYTES);
			4: v[LEN_W-1:0] = LEN_W'($urandom_range(PAT_BYTES + 1, (1 << LEN_W) - 1));
			default: v[LEN_W-1:0] = LEN_W'($urandom_range(2, PAT_BYTES - 1));
		endcase
		write_reg(REG_LENGTH, v);

		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = '1;
			2: v = 64'hFFFF_FFFF_FFFF_FFF0;
			default: v = {$urandom, $urandom};
		endcase
		write_reg(REG_START, v);

		// Writes past the last register must change nothing
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_START + 1, (1 << CFG_IDX_W) - 1)),
				{$urandom, $urandom});
		end_writes();
		settings_used++;
	endtask

	initial begin
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;

		// Zero length after reset: never matches
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b1);

		// Three-byte pattern AB ?? CD, start address at the top of the space
		settle(SETTLE_CYCLES);
		write_reg(REG_PAT_LOW, 64'h0000_0000_00CD_5AAB);
		write_reg(REG_PAT_HIGH, '1);
		write_reg(REG_CARE, 64'h0005);
		write_reg(REG_LENGTH, 64'd3);
		write_reg(REG_START, '1);
		end_writes();

		// Short region
		put_byte(8'hAB, 1'b0);
		put_byte(8'h5A, 1'b1);

		// Match completes on the last byte, address wraps to zero
		put_byte(8'h00, 1'b0);
		put_byte(8'hAB, 1'b0);
		put_byte(8'h77, 1'b0);
		put_byte(8'hCD, 1'b1);

		// First match wins, the second one and the last byte give nothing
		put_byte(8'hAB, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hCD, 1'b0);
		put_byte(8'hAB, 1'b0);
		put_byte(8'h55, 1'b0);
		put_byte(8'hCD, 1'b0);
		put_byte(8'h01, 1'b1);

		// Length above the window never matches; stray indexes are dropped
		settle(SETTLE_CYCLES);
		write_reg(REG_LENGTH, 64'd17);
		for (int k = REG_START + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), 64'd3);
		end_writes();
		put_byte(8'hAB, 1'b0);
		put_byte(8'h11, 1'b0);
		put_byte(8'hCD, 1'b1);

		// Change length, care and start in the middle of a region
		settle(SETTLE_CYCLES);
		write_reg(REG_LENGTH, 64'd3);
		end_writes();
		put_byte(8'hAB, 1'b0);
		put_byte(8'h12, 1'b0);
		settle(SETTLE_CYCLES);
		write_reg(REG_LENGTH, 64'd2);
		write_reg(REG_CARE, 64'd1);
		write_reg(REG_START, 64'h100);
		end_writes();
		put_byte(8'hAB, 1'b0);
		put_byte(8'h99, 1'b1);

		// Random settings, mostly regions with a planted pattern
		while (bytes_sent < RANDOM_BYTES) begin
			apply_setting();
			repeat ($urandom_range(3, 8)) begin
				if (bytes_sent >= CALM_FROM)
					calm = 1'b1;
				send_region($urandom_range(0, 9) < 7);
			end
		end

		settle(SETTLE_CYCLES * 4);
		$display("random part: %0d regions, %0d scanned bytes, %0d register settings",
			regions_sent, bytes_sent, settings_used);
		$display("results checked: %0d found, %0d not found, %0d mismatches",
			found_count, miss_count, mismatches);
		if (mismatches == 0 && results_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
